[rtl/cfsk_pkg.sv]
// cfsk_pkg: shared types, constants and wave tables for the cassette FSK generator.
// Used by cfsk_ctrl, cfsk_datapath and the top level; depends on nothing.
package cfsk_pkg;

    localparam int unsigned LANES      = 8;
    localparam int unsigned ROM_LEN    = 37;
    localparam int unsigned ROM_IDX_W  = 6;
    localparam int unsigned FRAME_BITS = 10;

    localparam logic [7:0] MID_LEVEL = 8'd128;

    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_TONE    = 2'd1;
    localparam logic [1:0] KIND_SILENCE = 2'd2;
    localparam logic [1:0] KIND_INVALID = 2'd3;

    localparam logic [7:0] WAVE_ZERO [0:ROM_LEN-1] = '{
        8'd128, 8'd139, 8'd149, 8'd159, 8'd168, 8'd176, 8'd183, 8'd188, 8'd191,
        8'd192, 8'd191, 8'd189, 8'd185, 8'd179, 8'd172, 8'd163, 8'd153, 8'd143,
        8'd132, 8'd121, 8'd110, 8'd100, 8'd91,  8'd83,  8'd76,  8'd70,  8'd66,
        8'd64,  8'd64,  8'd66,  8'd69,  8'd75,  8'd82,  8'd90,  8'd99,  8'd109,
        8'd120
    };

    localparam logic [7:0] WAVE_ONE [0:ROM_LEN-1] = '{
        8'd128, 8'd149, 8'd168, 8'd183, 8'd191, 8'd191, 8'd185, 8'd172, 8'd153,
        8'd132, 8'd110, 8'd91,  8'd76,  8'd66,  8'd64,  8'd69,  8'd82,  8'd99,
        8'd120, 8'd142, 8'd162, 8'd178, 8'd189, 8'd192, 8'd188, 8'd177, 8'd161,
        8'd140, 8'd118, 8'd98,  8'd81,  8'd69,  8'd64,  8'd67,  8'd76,  8'd92,
        8'd112
    };

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_GEN  = 2'b10
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic item_end;
        logic need_emit;
        logic out_busy;
    } t_sts;

    function automatic logic [7:0] wave_sample(input logic one,
                                               input logic [ROM_IDX_W-1:0] idx);
        logic [7:0] s;
        s = MID_LEVEL;
        if (idx < ROM_IDX_W'(ROM_LEN)) begin
            s = one ? WAVE_ONE[idx] : WAVE_ZERO[idx];
        end
        return s;
    endfunction

endpackage

[rtl/cfsk_ctrl.sv]
// cfsk_ctrl: item sequencer for the cassette FSK generator (idle / generate).
// Depends on cfsk_pkg; drives cfsk_datapath through t_cmd, reads t_sts.
module cfsk_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_kind,
    input  cfsk_pkg::t_sts      i_sts,
    output cfsk_pkg::t_cmd      o_cmd
);

    cfsk_pkg::t_state r_state, n_state;
    logic             accept;

    assign o_stall        = (r_state != cfsk_pkg::ST_IDLE);
    assign accept         = i_valid && !o_stall;
    assign o_cmd.load     = accept && (i_kind != cfsk_pkg::KIND_INVALID);
    assign o_cmd.step     = (r_state == cfsk_pkg::ST_GEN) &&
                            !(i_sts.need_emit && i_sts.out_busy);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cfsk_pkg::ST_IDLE: begin
                if (o_cmd.load) begin
                    n_state = cfsk_pkg::ST_GEN;
                end
            end
            cfsk_pkg::ST_GEN: begin
                if (o_cmd.step && i_sts.item_end) begin
                    n_state = cfsk_pkg::ST_IDLE;
                end
            end
            default: n_state = cfsk_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cfsk_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_step_only_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |-> (r_state == cfsk_pkg::ST_GEN))
        else $error("step issued outside generate state");

    a_end_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.step && i_sts.item_end) |=> (r_state == cfsk_pkg::ST_IDLE))
        else $error("controller did not return to idle at item end");

    a_no_emit_on_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sts.need_emit && i_sts.out_busy) |-> !o_cmd.step)
        else $error("group emitted while output register held");

    a_load_starts_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == cfsk_pkg::ST_GEN))
        else $error("load did not start generation");

endmodule

[rtl/cfsk_datapath.sv]
// cfsk_datapath: bit framing, cycle timing, wave lookup, group packing and output register.
// Depends on cfsk_pkg; commanded by cfsk_ctrl.
module cfsk_datapath #(
    parameter int unsigned LONG_CYCLE_SAMPLES = 37,
    parameter int unsigned CYCLES_PER_UNIT    = 10,
    parameter int unsigned SAMPLES_PER_GROUP  = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cfsk_pkg::t_cmd  i_cmd,
    output cfsk_pkg::t_sts  o_sts,
    input  logic [1:0]      i_kind,
    input  logic [7:0]      i_data_byte,
    input  logic            i_record_end,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [7:0]      o_sample [0:cfsk_pkg::LANES-1],
    output logic [3:0]      o_sample_count,
    output logic            o_last,
    output logic            o_record_done
);

    localparam int unsigned MAXC = (CYCLES_PER_UNIT > cfsk_pkg::FRAME_BITS) ?
                                   CYCLES_PER_UNIT : cfsk_pkg::FRAME_BITS;
    localparam int unsigned CW   = $clog2(MAXC);
    localparam int unsigned PW   = $clog2(LONG_CYCLE_SAMPLES);

    logic [1:0]                        r_phase, n_phase;
    logic                              r_oval, n_oval;
    logic [PW-1:0]                     r_pos, n_pos;
    logic [CW-1:0]                     r_left, n_left;
    logic [cfsk_pkg::FRAME_BITS-1:0]   r_bits, n_bits;
    logic                              r_tone, n_tone;
    logic                              r_silence, n_silence;
    logic                              r_rec_end, n_rec_end;
    logic [2:0]                        r_fill, n_fill;
    logic [7:0]                        r_buf [0:cfsk_pkg::LANES-1];
    logic [7:0]                        n_buf [0:cfsk_pkg::LANES-1];
    logic [7:0]                        r_osamp [0:cfsk_pkg::LANES-1];
    logic [7:0]                        n_osamp [0:cfsk_pkg::LANES-1];
    logic [3:0]                        r_ocount, n_ocount;
    logic                              r_olast, n_olast;
    logic                              r_odone, n_odone;

    logic [PW-1:0] last_pos;
    logic          pos_last;
    logic          item_end;
    logic          grp_full;
    logic          emit;
    logic [7:0]    cur_sample;

    assign last_pos   = (r_phase == 2'd0) ? PW'(LONG_CYCLE_SAMPLES - 2)
                                          : PW'(LONG_CYCLE_SAMPLES - 1);
    assign pos_last   = (r_pos == last_pos);
    assign item_end   = pos_last && (r_left == '0);
    assign grp_full   = (r_fill == 3'(SAMPLES_PER_GROUP - 1));
    assign emit       = i_cmd.step && (item_end || grp_full);
    assign cur_sample = r_silence ? cfsk_pkg::MID_LEVEL :
                        cfsk_pkg::wave_sample(r_tone | r_bits[0],
                                              cfsk_pkg::ROM_IDX_W'(r_pos));

    assign o_sts.item_end  = item_end;
    assign o_sts.need_emit = item_end || grp_full;
    assign o_sts.out_busy  = r_oval && i_stall;

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_left    = r_left;
        n_bits    = r_bits;
        n_tone    = r_tone;
        n_silence = r_silence;
        n_rec_end = r_rec_end;
        n_fill    = r_fill;
        n_buf     = r_buf;
        n_oval    = r_oval && i_stall;
        n_osamp   = r_osamp;
        n_ocount  = r_ocount;
        n_olast   = r_olast;
        n_odone   = r_odone;

        if (i_cmd.load) begin
            n_pos     = '0;
            n_bits    = {1'b1, i_data_byte, 1'b0};
            n_tone    = (i_kind == cfsk_pkg::KIND_TONE);
            n_silence = (i_kind == cfsk_pkg::KIND_SILENCE);
            n_rec_end = i_record_end;
            n_left    = (i_kind == cfsk_pkg::KIND_DATA) ? CW'(cfsk_pkg::FRAME_BITS - 1)
                                                       : CW'(CYCLES_PER_UNIT - 1);
            n_fill    = '0;
            for (int k = 0; k < cfsk_pkg::LANES; k++) begin
                n_buf[k] = cfsk_pkg::MID_LEVEL;
            end
        end else if (i_cmd.step) begin
            if (pos_last) begin
                n_pos   = '0;
                n_phase = r_phase + 2'd1;
                n_left  = r_left - CW'(1);
                n_bits  = {1'b0, r_bits[cfsk_pkg::FRAME_BITS-1:1]};
            end else begin
                n_pos = r_pos + PW'(1);
            end
            if (emit) begin
                n_fill = '0;
                for (int k = 0; k < cfsk_pkg::LANES; k++) begin
                    n_buf[k] = cfsk_pkg::MID_LEVEL;
                    if (3'(k) < r_fill) begin
                        n_osamp[k] = r_buf[k];
                    end else if (3'(k) == r_fill) begin
                        n_osamp[k] = cur_sample;
                    end else begin
                        n_osamp[k] = cfsk_pkg::MID_LEVEL;
                    end
                end
                n_oval   = 1'b1;
                n_ocount = {1'b0, r_fill} + 4'd1;
                n_olast  = item_end;
                n_odone  = item_end && r_rec_end;
            end else begin
                n_buf[r_fill] = cur_sample;
                n_fill        = r_fill + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
            r_oval  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_oval  <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_left    <= n_left;
        r_bits    <= n_bits;
        r_tone    <= n_tone;
        r_silence <= n_silence;
        r_rec_end <= n_rec_end;
        r_fill    <= n_fill;
        r_buf     <= n_buf;
        r_osamp   <= n_osamp;
        r_ocount  <= n_ocount;
        r_olast   <= n_olast;
        r_odone   <= n_odone;
    end

    assign o_valid        = r_oval;
    assign o_sample       = r_osamp;
    assign o_sample_count = r_ocount;
    assign o_last         = r_olast;
    assign o_record_done  = r_odone;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oval |-> (r_ocount != 4'd0 && r_ocount <= 4'(SAMPLES_PER_GROUP)))
        else $error("sample count out of range");

    a_done_needs_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oval && r_odone) |-> r_olast)
        else $error("record_done without last");

    a_phase_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && pos_last) |=> (r_phase == $past(r_phase) + 2'd1))
        else $error("cycle phase did not advance at cycle end");

endmodule

[rtl/cassette_fsk_sample_generator_core.sv]
// Top level of the cassette FSK sample generator: one item in, groups of audio samples out.
// Depends on cfsk_pkg, cfsk_ctrl and cfsk_datapath.
//
// Each accepted item (data byte framed as start 0, eight bits LSB first, stop 1; or a
// high-tone or silence unit of CYCLES_PER_UNIT wave periods) is expanded into bit cycles of
// LONG_CYCLE_SAMPLES-1 or LONG_CYCLE_SAMPLES samples, chosen by a running 2-bit phase.
// The datapath produces one sample per clock unless a finished group waits on a held
// output register; an item at the default settings yields 367 or 368 samples, set by
// the phase, and a full group carries SAMPLES_PER_GROUP samples. o_stall is high while
// an item is being expanded; a finished group waits in the output register while the
// next item is accepted. Kind 3 is taken and dropped.
module cassette_fsk_sample_generator_core #(
    parameter int unsigned LONG_CYCLE_SAMPLES = 37,
    parameter int unsigned CYCLES_PER_UNIT    = 10,
    parameter int unsigned SAMPLES_PER_GROUP  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_data_byte,
    input  logic        i_record_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_sample_0,
    output logic [7:0]  o_sample_1,
    output logic [7:0]  o_sample_2,
    output logic [7:0]  o_sample_3,
    output logic [7:0]  o_sample_4,
    output logic [7:0]  o_sample_5,
    output logic [7:0]  o_sample_6,
    output logic [7:0]  o_sample_7,
    output logic [3:0]  o_sample_count,
    output logic        o_last,
    output logic        o_record_done
);

    cfsk_pkg::t_cmd cmd;
    cfsk_pkg::t_sts sts;
    logic [7:0]     samples [0:cfsk_pkg::LANES-1];

    cfsk_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_kind  (i_kind),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    cfsk_datapath #(
        .LONG_CYCLE_SAMPLES (LONG_CYCLE_SAMPLES),
        .CYCLES_PER_UNIT    (CYCLES_PER_UNIT),
        .SAMPLES_PER_GROUP  (SAMPLES_PER_GROUP)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_kind         (i_kind),
        .i_data_byte    (i_data_byte),
        .i_record_end   (i_record_end),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_sample       (samples),
        .o_sample_count (o_sample_count),
        .o_last         (o_last),
        .o_record_done  (o_record_done)
    );

    assign o_sample_0 = samples[0];
    assign o_sample_1 = samples[1];
    assign o_sample_2 = samples[2];
    assign o_sample_3 = samples[3];
    assign o_sample_4 = samples[4];
    assign o_sample_5 = samples[5];
    assign o_sample_6 = samples[6];
    assign o_sample_7 = samples[7];

endmodule
